/* rtl/core/abst_pkg.sv */
// ----------------------------------------------------------------------------
// abst_pkg: shared types for the array search tree block
// Request kinds, result codes, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package abst_pkg;

   localparam int KIND_BITS   = 2;
   localparam int STATUS_BITS = 3;
   localparam int IO_KEY_BITS = 16;

   typedef enum logic [KIND_BITS-1:0] {
      REQ_INSERT    = 2'd0,
      REQ_INORDER   = 2'd1,
      REQ_PREORDER  = 2'd2,
      REQ_POSTORDER = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STS_INSERTED  = 3'd0,
      STS_DUPLICATE = 3'd1,
      STS_NO_ROOM   = 3'd2,
      STS_ZERO_KEY  = 3'd3,
      STS_LISTED    = 3'd4,
      STS_EMPTY     = 3'd5
   } rsp_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INSERT,
      ST_ROOT,
      ST_VISIT,
      ST_LEFT,
      ST_MID,
      ST_RIGHT,
      ST_POST,
      ST_UP_MID,
      ST_UP_POST,
      ST_FLUSH
   } state_type;

   // slot address sources
   typedef enum logic [2:0] {
      ASEL_ROOT,
      ASEL_LEFT,
      ASEL_RIGHT,
      ASEL_PARENT,
      ASEL_NEXT
   } addr_sel_type;

   // pending result key sources
   typedef enum logic [1:0] {
      KSEL_ZERO,
      KSEL_REQ,
      KSEL_READ,
      KSEL_NODE
   } key_sel_type;

   typedef struct packed {
      logic           req_load;
      logic           clr_step;
      logic           wr_en;
      logic           rd_en;
      addr_sel_type   addr_sel;
      logic           slot_load;
      logic           node_load;
      logic           pend_load;
      key_sel_type    pend_key_sel;
      rsp_status_type pend_status;
      logic           pend_clear;
      logic           push_out;
      logic           out_last;
   } cmd_type;

   typedef struct packed {
      logic         clr_last;
      logic         in_key_zero;
      req_kind_type kind;
      logic         rd_zero;
      logic         key_eq;
      logic         key_lt;
      logic         next_ok;
      logic         left_ok;
      logic         right_ok;
      logic         is_root;
      logic         slot_odd;
      logic         pend_valid;
   } stat_type;

endpackage

/* rtl/core/abst_dpath.sv */
// ----------------------------------------------------------------------------
// abst_dpath: slot store and walk registers
// Holds the key memory, the current slot, the node key and the pending
// result; performs the address arithmetic and compares for the controller.
// ----------------------------------------------------------------------------
module abst_dpath #(
   parameter int TREE_SLOTS = 63,
   parameter int KEY_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  abst_pkg::cmd_type                    cmd,
   input  abst_pkg::req_kind_type               in_kind,
   input  logic [abst_pkg::IO_KEY_BITS-1:0]     in_key,
   output abst_pkg::stat_type                   stat,
   output logic [abst_pkg::IO_KEY_BITS-1:0]     pend_key,
   output abst_pkg::rsp_status_type             pend_status
);
   import abst_pkg::*;

   localparam int SW = $clog2(2 * TREE_SLOTS + 2);
   localparam int AW = $clog2(TREE_SLOTS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(TREE_SLOTS);
   localparam logic [SW-1:0] ROOT_SLOT = SW'(1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TREE_SLOTS - 1);

   logic [KEY_BITS-1:0] slot_mem [TREE_SLOTS];

   logic [SW-1:0]       slot_ff, slot_in;
   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] node_ff;
   logic [KEY_BITS-1:0] rd_data_ff;
   logic [KEY_BITS-1:0] pend_key_ff, pend_key_in;
   rsp_status_type      pend_status_ff;
   logic                pend_valid_ff, pend_valid_in;
   req_kind_type        kind_ff;
   logic [AW-1:0]       clr_ff, clr_in;

   logic [31:0]         in_key32;
   logic [KEY_BITS-1:0] in_key_w;
   logic [31:0]         pend_key32;
   logic [SW-1:0]       left_val, right_val, parent_val, next_val, addr_val;
   logic [SW-1:0]       addr_m1, slot_m1;
   logic                key_lt;

   assign in_key32 = 32'(in_key);
   assign in_key_w = in_key32[KEY_BITS-1:0];

   assign key_lt     = key_ff < rd_data_ff;
   assign left_val   = {slot_ff[SW-2:0], 1'b0};
   assign right_val  = {slot_ff[SW-2:0], 1'b1};
   assign parent_val = {1'b0, slot_ff[SW-1:1]};
   assign next_val   = key_lt ? left_val : right_val;

   always_comb begin
      case (cmd.addr_sel)
         ASEL_ROOT:   addr_val = ROOT_SLOT;
         ASEL_LEFT:   addr_val = left_val;
         ASEL_RIGHT:  addr_val = right_val;
         ASEL_PARENT: addr_val = parent_val;
         ASEL_NEXT:   addr_val = next_val;
         default:     addr_val = ROOT_SLOT;
      endcase
   end

   // slots are numbered from 1, memory rows from 0
   assign addr_m1 = addr_val - ROOT_SLOT;
   assign slot_m1 = slot_ff - ROOT_SLOT;

   always_comb begin
      case (cmd.pend_key_sel)
         KSEL_ZERO: pend_key_in = '0;
         KSEL_REQ:  pend_key_in = key_ff;
         KSEL_READ: pend_key_in = rd_data_ff;
         KSEL_NODE: pend_key_in = node_ff;
         default:   pend_key_in = '0;
      endcase
   end

   assign slot_in       = cmd.slot_load ? addr_val : slot_ff;
   assign clr_in        = cmd.clr_step ? clr_ff + AW'(1) : clr_ff;
   assign pend_valid_in = cmd.pend_load ? 1'b1 : (cmd.pend_clear ? 1'b0 : pend_valid_ff);

   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         slot_mem[clr_ff] <= '0;
      end else if (cmd.wr_en) begin
         slot_mem[slot_m1[AW-1:0]] <= key_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= slot_mem[addr_m1[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (cmd.req_load) begin
         key_ff  <= in_key_w;
         kind_ff <= in_kind;
      end
      if (cmd.node_load) begin
         node_ff <= rd_data_ff;
      end
      if (cmd.pend_load) begin
         pend_key_ff    <= pend_key_in;
         pend_status_ff <= cmd.pend_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         clr_ff        <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         clr_ff        <= clr_in;
      end
   end

   assign pend_key32  = 32'(pend_key_ff);
   assign pend_key    = pend_key32[IO_KEY_BITS-1:0];
   assign pend_status = pend_status_ff;

   always_comb begin
      stat.clr_last    = clr_ff == LAST_ADDR;
      stat.in_key_zero = in_key_w == '0;
      stat.kind        = kind_ff;
      stat.rd_zero     = rd_data_ff == '0;
      stat.key_eq      = key_ff == rd_data_ff;
      stat.key_lt      = key_lt;
      stat.next_ok     = next_val <= LAST_SLOT;
      stat.left_ok     = left_val <= LAST_SLOT;
      stat.right_ok    = right_val <= LAST_SLOT;
      stat.is_root     = slot_ff == ROOT_SLOT;
      stat.slot_odd    = slot_ff[0];
      stat.pend_valid  = pend_valid_ff;
   end

`ifndef SYNTHESIS
   a_read_in_store: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (addr_val >= ROOT_SLOT) && (addr_val <= LAST_SLOT))
      else $error("slot read outside the store");
`endif

endmodule

/* rtl/core/abst_ctrl.sv */
// ----------------------------------------------------------------------------
// abst_ctrl: walk sequencer
// Runs the clearing sweep, the insert descent and the stackless tree walk,
// and hands each emitted key to the pending result register.
// ----------------------------------------------------------------------------
module abst_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  abst_pkg::req_kind_type req_kind,
   input  logic                   out_free,
   input  abst_pkg::stat_type     stat,
   output logic                   req_tready,
   output abst_pkg::cmd_type      cmd
);
   import abst_pkg::*;

   state_type state_ff, state_in;
   logic      emit_want, emit_ok, hold;

   // a key is emitted at the visit matching the order of the listing
   assign emit_want = ((state_ff == ST_VISIT) && (stat.kind == REQ_PREORDER)) ||
                      ((state_ff == ST_MID)   && (stat.kind == REQ_INORDER))  ||
                      ((state_ff == ST_POST)  && (stat.kind == REQ_POSTORDER));
   assign emit_ok   = !stat.pend_valid || out_free;
   assign hold      = emit_want && !emit_ok;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_kind != REQ_INSERT) state_in = ST_ROOT;
               else if (stat.in_key_zero)  state_in = ST_FLUSH;
               else                        state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            if (stat.rd_zero || stat.key_eq || !stat.next_ok) state_in = ST_FLUSH;
         end
         ST_ROOT: begin
            state_in = stat.rd_zero ? ST_FLUSH : ST_VISIT;
         end
         ST_VISIT: begin
            if (!hold) state_in = stat.left_ok ? ST_LEFT : ST_MID;
         end
         ST_LEFT: begin
            state_in = stat.rd_zero ? ST_MID : ST_VISIT;
         end
         ST_MID: begin
            if (!hold) state_in = stat.right_ok ? ST_RIGHT : ST_POST;
         end
         ST_RIGHT: begin
            state_in = stat.rd_zero ? ST_POST : ST_VISIT;
         end
         ST_POST: begin
            if (!hold) begin
               if (stat.is_root)       state_in = ST_FLUSH;
               else if (stat.slot_odd) state_in = ST_UP_POST;
               else                    state_in = ST_UP_MID;
            end
         end
         ST_UP_MID:  state_in = ST_MID;
         ST_UP_POST: state_in = ST_POST;
         ST_FLUSH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;

      // move the previous key out, park the new one
      if (emit_want && !hold) begin
         cmd.pend_load    = 1'b1;
         cmd.pend_key_sel = (state_ff == ST_VISIT) ? KSEL_READ : KSEL_NODE;
         cmd.pend_status  = STS_LISTED;
         cmd.push_out     = stat.pend_valid;
      end

      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.req_load = 1'b1;
               if ((req_kind == REQ_INSERT) && stat.in_key_zero) begin
                  cmd.pend_load    = 1'b1;
                  cmd.pend_key_sel = KSEL_ZERO;
                  cmd.pend_status  = STS_ZERO_KEY;
               end else begin
                  cmd.rd_en     = 1'b1;
                  cmd.addr_sel  = ASEL_ROOT;
                  cmd.slot_load = 1'b1;
               end
            end
         end
         ST_INSERT: begin
            cmd.pend_key_sel = KSEL_REQ;
            if (stat.rd_zero) begin
               cmd.wr_en       = 1'b1;
               cmd.pend_load   = 1'b1;
               cmd.pend_status = STS_INSERTED;
            end else if (stat.key_eq) begin
               cmd.pend_load   = 1'b1;
               cmd.pend_status = STS_DUPLICATE;
            end else if (!stat.next_ok) begin
               cmd.pend_load   = 1'b1;
               cmd.pend_status = STS_NO_ROOM;
            end else begin
               cmd.rd_en     = 1'b1;
               cmd.addr_sel  = ASEL_NEXT;
               cmd.slot_load = 1'b1;
            end
         end
         ST_ROOT: begin
            if (stat.rd_zero) begin
               cmd.pend_load    = 1'b1;
               cmd.pend_key_sel = KSEL_ZERO;
               cmd.pend_status  = STS_EMPTY;
            end
         end
         ST_VISIT: begin
            if (!hold) begin
               cmd.node_load = 1'b1;
               if (stat.left_ok) begin
                  cmd.rd_en    = 1'b1;
                  cmd.addr_sel = ASEL_LEFT;
               end
            end
         end
         ST_LEFT: begin
            if (!stat.rd_zero) begin
               cmd.addr_sel  = ASEL_LEFT;
               cmd.slot_load = 1'b1;
            end
         end
         ST_MID: begin
            if (!hold && stat.right_ok) begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ASEL_RIGHT;
            end
         end
         ST_RIGHT: begin
            if (!stat.rd_zero) begin
               cmd.addr_sel  = ASEL_RIGHT;
               cmd.slot_load = 1'b1;
            end
         end
         ST_POST: begin
            if (!hold && !stat.is_root) begin
               cmd.rd_en     = 1'b1;
               cmd.addr_sel  = ASEL_PARENT;
               cmd.slot_load = 1'b1;
            end
         end
         ST_UP_MID, ST_UP_POST: begin
            cmd.node_load = 1'b1;
         end
         ST_FLUSH: begin
            if (out_free) begin
               cmd.push_out   = 1'b1;
               cmd.out_last   = 1'b1;
               cmd.pend_clear = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_push_has_data: assert property (@(posedge clock) disable iff (reset)
      cmd.push_out |-> stat.pend_valid && out_free)
      else $error("result pushed without a pending key or a free output");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.pend_load && stat.pend_valid) |-> cmd.push_out)
      else $error("pending key overwritten before it was sent");

   a_flush_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && out_free) |=> !stat.pend_valid && state_ff == ST_IDLE)
      else $error("final result did not drain the pending register");
`endif

endmodule

/* rtl/core/array_bst_insert_traverse.sv */
// ----------------------------------------------------------------------------
// array_bst_insert_traverse: binary search tree in an implicit slot store
// Top level: request and result channels, result register, sequencer and
// datapath.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one request per handshake: tuser selects insert,
//   inorder, preorder or postorder listing, tdata carries the key to insert.
//   The rsp channel returns one result for an insert (key echoed, status in
//   tuser) and one result per stored key for a listing, tlast on the final
//   one; an empty tree gives a single result with status empty.
//   Requests are taken one at a time. An insert walks down one tree level
//   at a time, bounded by the depth of the slot store. A listing visits
//   every stored key and probes each child slot of it that lies inside the
//   store; the one read port of the slot memory serves one child probe or
//   one step back up at a time.
//   After reset a clearing sweep writes every slot to empty, with req_tready low.
//   A stalled rsp side holds the result register; the walk then waits with
//   one key parked in the pending register and resumes when tready returns.
// ----------------------------------------------------------------------------
module array_bst_insert_traverse #(
   parameter int TREE_SLOTS = 63,
   parameter int KEY_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [abst_pkg::IO_KEY_BITS-1:0]     req_tdata,   // [15:0] key_in
   input  logic [abst_pkg::KIND_BITS-1:0]       req_tuser,   // [1:0] req_type
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [abst_pkg::IO_KEY_BITS-1:0]     rsp_tdata,   // [15:0] key_out
   output logic [abst_pkg::STATUS_BITS-1:0]     rsp_tuser,   // [2:0] status
   output logic                                 rsp_tlast
);
   import abst_pkg::*;

   cmd_type                  cmd;
   stat_type                 stat;
   req_kind_type             req_kind;
   logic [IO_KEY_BITS-1:0]   pend_key;
   rsp_status_type           pend_status;
   logic                     out_free;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IO_KEY_BITS-1:0]   rsp_key_ff;
   rsp_status_type           rsp_status_ff;
   logic                     rsp_last_ff;

   assign req_kind = req_kind_type'(req_tuser);

   // the result register is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   abst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_kind),
      .out_free   (out_free),
      .stat       (stat),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   abst_dpath #(
      .TREE_SLOTS (TREE_SLOTS),
      .KEY_BITS   (KEY_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_kind     (req_kind),
      .in_key      (req_tdata),
      .stat        (stat),
      .pend_key    (pend_key),
      .pend_status (pend_status)
   );

   // load on a push, drop once the receiver takes it
   assign rsp_valid_in = cmd.push_out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the payload until the next push
   always_ff @(posedge clock) begin
      if (cmd.push_out) begin
         rsp_key_ff    <= pend_key;
         rsp_status_ff <= pend_status;
         rsp_last_ff   <= cmd.out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_key_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
